// ----- design/scu_pkg.sv -----
// ----------------------------------------------------------------------------
// scu_pkg - shared types and constants of the sine / cosine unit
// Fixed-point formats of the internal datapath and the record that the
// Taylor cells pass along the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scu_pkg;

  // Internal angle and series arithmetic runs on unsigned Q30 magnitudes
  localparam int QF      = 30;
  localparam int MW      = 34;  // angle magnitude in Q30, up to 2^33
  localparam int RW      = 31;  // remainder within one quadrant
  localparam int TW      = 32;  // series term and squared remainder
  localparam int SW      = 34;  // signed partial sum
  localparam int N_CELLS = 8;   // one cell per series step

  localparam logic [MW-1:0] HALF_PI_Q   = 34'd1686629713;
  localparam logic [MW-1:0] PI_Q        = 34'd3373259426;
  localparam logic [MW-1:0] THREE_HPI_Q = 34'd5059889139;
  localparam logic [MW-1:0] TWO_PI_Q    = 34'd6746518852;
  localparam logic [TW-1:0] ONE_Q       = 32'h4000_0000;

  // Record handed from cell to cell
  typedef struct packed {
    logic [TW-1:0]        term;  // current term, not yet in the sum
    logic signed [SW-1:0] sum;   // sum of the earlier terms
    logic [TW-1:0]        r2;    // squared quadrant remainder, Q30
    logic                 sine;  // 1: sine series, 0: cosine series
    logic                 neg;   // result is negated at the end
  } scu_cell_t;

endpackage

// ----- design/scu_if.sv -----
// ----------------------------------------------------------------------------
// scu_if - item channels of the sine / cosine unit
// Valid / ready channels for the angle items and the result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Angle channel
interface scu_in_if #(
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, mode, angle, input ready);
  modport sink   (input valid, mode, angle, output ready);
endinterface

// Result channel
interface scu_out_if #(
  parameter int OUT_FRAC_BITS = 14
);
  logic                            valid;
  logic                            ready;
  logic signed [OUT_FRAC_BITS+1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

// ----- design/scu_front.sv -----
// ----------------------------------------------------------------------------
// scu_front - angle reduction and quadrant fold
// Scales the angle magnitude to Q30, removes a whole period, folds into a
// quadrant and squares the remainder to seed the Taylor chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scu_front import scu_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  scu_in_if.sink    in_ch,
  output logic      dn_valid,
  input  logic      dn_ready,
  output scu_cell_t dn_data
);

  // Stage occupancy and load enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4 = !v4_r || dn_ready;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_ch.ready = ld1;
  assign dn_valid    = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_ch.valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

  // Stage 1: magnitude in Q30, sign kept apart
  logic [ANGLE_WIDTH-1:0] ang_u;
  logic [ANGLE_WIDTH-1:0] mag;
  logic [MW-1:0]          m1_nxt, m1_r;
  logic                   aneg1_r, mode1_r;

  always_comb begin
    ang_u  = in_ch.angle;
    mag    = ang_u[ANGLE_WIDTH-1] ? (~ang_u + 1'b1) : ang_u;
    m1_nxt = {mag, {(MW-ANGLE_WIDTH){1'b0}}};
  end

  // Stage 2: at most one whole period to remove
  logic [MW-1:0] m2_nxt, m2_r;
  logic          aneg2_r, mode2_r;

  assign m2_nxt = (m1_r > TWO_PI_Q) ? (m1_r - TWO_PI_Q) : m1_r;

  // Stage 3: quadrant index and remainder; exactly one period folds to zero
  logic [1:0]    quad;
  logic [MW-1:0] base;
  logic [MW-1:0] r_full;
  logic [RW-1:0] r3_nxt, r3_r;
  logic          sine3_nxt, neg3_nxt, sine3_r, neg3_r;

  always_comb begin
    if (m2_r >= TWO_PI_Q) begin
      quad = 2'd0;
      base = TWO_PI_Q;
    end else if (m2_r >= THREE_HPI_Q) begin
      quad = 2'd3;
      base = THREE_HPI_Q;
    end else if (m2_r >= PI_Q) begin
      quad = 2'd2;
      base = PI_Q;
    end else if (m2_r >= HALF_PI_Q) begin
      quad = 2'd1;
      base = HALF_PI_Q;
    end else begin
      quad = 2'd0;
      base = '0;
    end
    r_full    = m2_r - base;
    r3_nxt    = r_full[RW-1:0];
    sine3_nxt = mode2_r ^ quad[0];
    // sine flips in the lower half-turn and with the angle sign;
    // cosine is negative in the second and third quadrants
    neg3_nxt  = mode2_r ? (quad[1] ^ aneg2_r) : (quad[1] ^ quad[0]);
  end

  // Stage 4: square of the remainder, first term of the series
  logic [2*RW-1:0] sq;
  scu_cell_t       seed_nxt;

  always_comb begin
    sq            = r3_r * r3_r;
    seed_nxt.r2   = sq[QF+TW-1:QF];
    seed_nxt.term = sine3_r ? {1'b0, r3_r} : ONE_Q;
    seed_nxt.sum  = '0;
    seed_nxt.sine = sine3_r;
    seed_nxt.neg  = neg3_r;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ld1 && in_ch.valid) begin
      m1_r    <= m1_nxt;
      aneg1_r <= ang_u[ANGLE_WIDTH-1];
      mode1_r <= in_ch.mode;
    end
    if (ld2 && v1_r) begin
      m2_r    <= m2_nxt;
      aneg2_r <= aneg1_r;
      mode2_r <= mode1_r;
    end
    if (ld3 && v2_r) begin
      r3_r    <= r3_nxt;
      sine3_r <= sine3_nxt;
      neg3_r  <= neg3_nxt;
    end
    if (ld4 && v3_r) begin
      dn_data <= seed_nxt;
    end
  end

  // Reduced angle never exceeds one period
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (m2_r <= TWO_PI_Q))
    else $error("reduced angle above one period");

  // Quadrant remainder stays below a quarter period
  a_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (MW'(r3_r) < HALF_PI_Q))
    else $error("quadrant remainder out of range");

endmodule

// ----- design/scu_cell.sv -----
// ----------------------------------------------------------------------------
// scu_cell - one step of the Taylor chain
// Adds its incoming term to the sum and derives the next term as
// (term * r^2) / (d * (d + 1)), the division done by reciprocal product
// with a single correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scu_cell import scu_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  scu_cell_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output scu_cell_t dn_data
);

  // Denominators of this step for both series and their reciprocals
  localparam int D_COS = (2 * IDX + 1) * (2 * IDX + 2);
  localparam int D_SIN = (2 * IDX + 2) * (2 * IDX + 3);
  localparam int DW    = $clog2(D_SIN + 1);
  localparam logic [DW-1:0] DC = DW'(D_COS);
  localparam logic [DW-1:0] DS = DW'(D_SIN);
  localparam logic [TW-1:0] M_COS = TW'((64'd1 << TW) / 64'(D_COS));
  localparam logic [TW-1:0] M_SIN = TW'((64'd1 << TW) / 64'(D_SIN));
  localparam bit ADD_TERM = ((IDX % 2) == 0);

  // Occupancy and load enables
  logic va_r, vb_r, vc_r;
  logic lda, ldb, ldc;

  assign ldc      = !vc_r || dn_ready;
  assign ldb      = !vb_r || ldc;
  assign lda      = !va_r || ldb;
  assign up_ready = lda;
  assign dn_valid = vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (lda) va_r <= up_valid;
      if (ldb) vb_r <= va_r;
      if (ldc) vc_r <= vb_r;
    end
  end

  // Stage A: accumulate the term, multiply it by r^2
  logic [2*TW-1:0]      pa;
  logic signed [SW-1:0] term_ext;
  logic signed [SW-1:0] suma_nxt, suma_r, sumb_r;
  logic [TW-1:0]        xa_r, r2a_r, r2b_r;
  logic                 sinea_r, nega_r, sineb_r, negb_r;

  always_comb begin
    pa       = up_data.term * up_data.r2;
    term_ext = SW'(up_data.term);
    suma_nxt = ADD_TERM ? (up_data.sum + term_ext) : (up_data.sum - term_ext);
  end

  // Stage B: quotient estimate, low by at most one
  logic [TW-1:0]   mrec;
  logic [2*TW-1:0] pb;
  logic [TW-1:0]   q0b_r, xb_r;

  always_comb begin
    mrec = sinea_r ? M_SIN : M_COS;
    pb   = xa_r * mrec;
  end

  // Stage C: remainder check and correction
  logic [DW-1:0]    dsel;
  logic [TW+DW-1:0] qd;
  logic [TW-1:0]    rem;
  scu_cell_t        out_nxt;

  always_comb begin
    dsel         = sineb_r ? DS : DC;
    qd           = q0b_r * dsel;
    rem          = xb_r - qd[TW-1:0];
    out_nxt.term = (rem >= TW'(dsel)) ? (q0b_r + 1'b1) : q0b_r;
    out_nxt.sum  = sumb_r;
    out_nxt.r2   = r2b_r;
    out_nxt.sine = sineb_r;
    out_nxt.neg  = negb_r;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (lda && up_valid) begin
      xa_r    <= pa[QF+TW-1:QF];
      suma_r  <= suma_nxt;
      r2a_r   <= up_data.r2;
      sinea_r <= up_data.sine;
      nega_r  <= up_data.neg;
    end
    if (ldb && va_r) begin
      q0b_r   <= pb[2*TW-1:TW];
      xb_r    <= xa_r;
      sumb_r  <= suma_r;
      r2b_r   <= r2a_r;
      sineb_r <= sinea_r;
      negb_r  <= nega_r;
    end
    if (ldc && vb_r) begin
      dn_data <= out_nxt;
    end
  end

  // Reciprocal estimate is never more than one below the true quotient
  a_estimate: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (rem < (TW'(dsel) << 1)))
    else $error("quotient estimate off by more than one");

endmodule

// ----- design/scu_back.sv -----
// ----------------------------------------------------------------------------
// scu_back - series completion and output rounding
// Adds the last cosine term, clamps at zero, rounds to the output format,
// saturates at one and applies the sign into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scu_back import scu_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  scu_cell_t up_data,
  scu_out_if.source out_ch
);

  localparam int VW    = OUT_FRAC_BITS + 2;
  localparam int SHIFT = QF - OUT_FRAC_BITS;
  localparam logic [SW-1:0] RND_HALF = (SW'(1) << SHIFT) >> 1;
  localparam logic [SW-1:0] ONE_R    = SW'(1) << OUT_FRAC_BITS;
  localparam logic signed [VW-1:0] ONE_S     = VW'(1) << OUT_FRAC_BITS;
  localparam logic signed [VW-1:0] NEG_ONE_S = -ONE_S;

  // Occupancy and load enables
  logic v1_r, v2_r, v3_r;
  logic ld1, ld2, ld3;

  assign ld3          = !v3_r || out_ch.ready;
  assign ld2          = !v2_r || ld3;
  assign ld1          = !v1_r || ld2;
  assign up_ready     = ld1;
  assign out_ch.valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= up_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  // Stage 1: the cosine series carries one more term
  logic signed [SW-1:0] last_t;
  logic signed [SW-1:0] fin1_nxt, fin1_r;
  logic                 neg1_r;

  always_comb begin
    last_t   = up_data.sine ? '0 : SW'(up_data.term);
    fin1_nxt = up_data.sum + last_t;
  end

  // Stage 2: clamp overshoot below zero, round half away from zero
  logic [SW-1:0] clamp;
  logic [SW-1:0] rnd;
  logic [SW-1:0] res2_nxt, res2_r;
  logic          neg2_r;

  always_comb begin
    clamp    = fin1_r[SW-1] ? '0 : fin1_r;
    rnd      = clamp + RND_HALF;
    res2_nxt = rnd >> SHIFT;
  end

  // Stage 3: saturate at one, apply the sign
  logic [VW-1:0] mag3;
  logic [VW-1:0] val3_nxt;

  always_comb begin
    mag3     = (res2_r > ONE_R) ? ONE_R[VW-1:0] : res2_r[VW-1:0];
    val3_nxt = neg2_r ? (~mag3 + 1'b1) : mag3;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ld1 && up_valid) begin
      fin1_r <= fin1_nxt;
      neg1_r <= up_data.neg;
    end
    if (ld2 && v1_r) begin
      res2_r <= res2_nxt;
      neg2_r <= neg1_r;
    end
    if (ld3 && v2_r) begin
      out_ch.value <= val3_nxt;
    end
  end

  // A delivered result never leaves the range minus one to one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.value <= ONE_S) && (out_ch.value >= NEG_ONE_S)))
    else $error("result outside unit range");

endmodule

// ----- design/sine_cosine_unit.sv -----
// ----------------------------------------------------------------------------
// sine_cosine_unit - fixed-point sine and cosine of an angle in radians
// Each item carries a signed Q4.12 angle and a mode bit (0 cosine, 1 sine)
// and yields one signed Q1.14 result, rounded to nearest. The angle is
// reduced by a whole period, folded into a quadrant and run through a
// fixed-length Taylor series held in a chain of eight cells, three register
// stages each (term product, reciprocal product, correction), behind four
// reduction stages and three rounding stages. The chain is fully pipelined,
// so a new item is taken in every cycle in which the stages ahead can move,
// and an item may enter while earlier results still wait on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_cosine_unit import scu_pkg::*; #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  scu_in_if.sink    in_ch,
  scu_out_if.source out_ch
);

  // Links along the chain, front end at index zero
  logic [N_CELLS:0] c_valid;
  logic [N_CELLS:0] c_ready;
  scu_cell_t        c_data [N_CELLS+1];

  // Reduction, quadrant fold and seed
  scu_front #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_data  (c_data[0])
  );

  // Taylor chain
  for (genvar g = 0; g < N_CELLS; g++) begin : g_chain
    scu_cell #(
      .IDX (g)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[g]),
      .up_ready (c_ready[g]),
      .up_data  (c_data[g]),
      .dn_valid (c_valid[g+1]),
      .dn_ready (c_ready[g+1]),
      .dn_data  (c_data[g+1])
    );
  end

  // Completion, rounding and result register
  scu_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid[N_CELLS]),
    .up_ready (c_ready[N_CELLS]),
    .up_data  (c_data[N_CELLS]),
    .out_ch   (out_ch)
  );

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the sine / cosine unit
// Sends corner angles in both modes, then a random mix of full-range, small
// and near-quadrant angles through the valid / ready channel. Each accepted
// item is predicted in fixed point (period reduction, quadrant fold, Taylor
// series, rounding) and the result stream is checked in order. The sender
// works in bursts, the receiver stalls on its own pattern, with one long
// output hold-off and a few pauses until the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int ANGLE_W      = 16;
  localparam int OUT_FRAC     = 14;
  localparam int OUT_W        = OUT_FRAC + 2;
  localparam int FRAC         = 30;
  localparam int ROUND_SHIFT  = FRAC - OUT_FRAC;
  localparam int RESET_CYCLES = 8;
  localparam int N_RANDOM     = 850;
  localparam int PIPE_LATENCY = 30;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 250;
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_CYCLES = 400000;
  localparam int QUARTER_TURN = 6434;  // pi/2 in Q4.12, rounded

  localparam logic [63:0] TWO_PI_FX  = 64'd6746518852;
  localparam logic [63:0] HALF_PI_FX = 64'd1686629713;
  localparam logic [63:0] UNIT_FX    = 64'd1 << FRAC;
  localparam logic [63:0] OUT_UNIT   = 64'd1 << OUT_FRAC;

  // Corner angles: zero, smallest steps, extremes, quadrant edges, one period
  localparam int N_CORNER = 12;
  localparam logic signed [ANGLE_W-1:0] CORNER_ANGLES [N_CORNER] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd32767, 16'sh8000, 16'sd6434,
    -16'sd6434, 16'sd12868, 16'sd19302, 16'sd25735, 16'sd25736, -16'sd25736
  };

  typedef enum logic {
    MODE_COS = 1'b0,
    MODE_SIN = 1'b1
  } trig_mode_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_COMB
  } rx_style_t;

  typedef struct {
    trig_mode_t                  mode;
    logic signed [ANGLE_W-1:0]   angle;
    bit                          wait_drain;  // sender holds until all results are in
  } angle_item_t;

  typedef struct {
    trig_mode_t                  mode;
    logic signed [ANGLE_W-1:0]   angle;
    logic signed [OUT_W-1:0]     value;
  } trig_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  scu_in_if  #(.ANGLE_WIDTH(ANGLE_W))    in_ch ();
  scu_out_if #(.OUT_FRAC_BITS(OUT_FRAC)) out_ch ();

  sine_cosine_unit #(
    .ANGLE_WIDTH  (ANGLE_W),
    .OUT_FRAC_BITS(OUT_FRAC)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  angle_item_t  angle_queue   [$];
  trig_result_t trig_expected [$];

  bit        in_taken;
  int        burst_left;
  int        gap_left;
  int        drain_pauses;
  int        items_sent;
  int        sine_items;
  int        neg_items;
  int        results_seen;
  int        fail_count;
  int        hold_left;
  bit        hold_done;
  int        phase_left;
  int        rx_tick;
  rx_style_t rx_style;
  int        cycle_count;

  // Alternating series t0 - t1 + t2 - ..., each term truncated, clamped at 0
  function automatic logic [63:0] alt_series(logic [63:0] t0, logic [63:0] r2,
                                             int unsigned d0, int unsigned n);
    logic signed [63:0] acc;
    logic [63:0]        term;
    logic [63:0]        d;
    int unsigned        k;
    acc  = t0;
    term = t0;
    for (k = 0; k < n; k++) begin
      d    = 64'(2 * k + d0);
      term = ((term * r2) >> FRAC) / (d * (d + 64'd1));
      if (k % 2 == 0) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  // Expected Q1.14 value of cos / sin of a Q4.12 angle
  function automatic logic signed [OUT_W-1:0] predict_trig(trig_mode_t mode,
                                                           logic signed [ANGLE_W-1:0] ang);
    logic        neg_ang;
    logic        flip;
    logic [63:0] raw, mag, m, q, r, r2, s, c, res, neg_res;
    neg_ang = ang[ANGLE_W-1];
    raw     = {48'd0, ang};
    mag     = neg_ang ? (64'd1 << ANGLE_W) - raw : raw;
    m       = mag << (34 - ANGLE_W);
    if (m > TWO_PI_FX) m = m - (m / TWO_PI_FX) * TWO_PI_FX;
    q  = m / HALF_PI_FX;
    r  = m - q * HALF_PI_FX;
    q  = q & 64'd3;
    r2 = (r * r) >> FRAC;
    s  = alt_series(r, r2, 2, 7);
    c  = alt_series(UNIT_FX, r2, 1, 8);
    if (mode == MODE_SIN) begin
      res  = q[0] ? c : s;
      flip = (q >= 64'd2) ^ neg_ang;
    end else begin
      res  = q[0] ? s : c;
      flip = (q == 64'd1) || (q == 64'd2);
    end
    // round half away from zero on the magnitude, then saturate at 1.0
    res = (res + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (res > OUT_UNIT) res = OUT_UNIT;
    neg_res = (64'd1 << OUT_W) - res;
    return (flip && res != 0) ? neg_res[OUT_W-1:0] : res[OUT_W-1:0];
  endfunction

  // Clock
  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, trig_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sender: bursts of items with gaps, optional wait for an empty pipeline
  always @(negedge clk) begin : driver
    angle_item_t nxt;
    logic        v_next;
    v_next = in_ch.valid;
    if (!rst_n) begin
      v_next = 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      v_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (angle_queue.size() != 0 &&
                   (!angle_queue[0].wait_drain || trig_expected.size() == 0)) begin
        nxt = angle_queue.pop_front();
        if (nxt.wait_drain) drain_pauses++;
        in_ch.mode  <= nxt.mode;
        in_ch.angle <= nxt.angle;
        v_next = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_ch.valid <= v_next;
  end

  // Receiver: changing stall styles plus one long hold-off
  always @(negedge clk) begin : receiver
    logic r_next;
    if (!rst_n) begin
      r_next = 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        r_next = 1'b0;
      end else begin
        if (phase_left == 0) begin
          rx_style   = rx_style_t'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        rx_tick++;
        case (rx_style)
          RX_OPEN:   r_next = 1'b1;
          RX_COIN:   r_next = 1'($urandom_range(0, 1));
          RX_SPARSE: r_next = ($urandom_range(0, 3) == 0);
          default:   r_next = (rx_tick % 4) != 0;
        endcase
      end
    end
    out_ch.ready <= r_next;
  end

  // Scoreboard: predict on input acceptance, check results in order
  always @(posedge clk) begin : scoreboard
    trig_result_t exp_r;
    trig_mode_t   m_in;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (trig_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] unexpected result %0d with nothing pending",
                     $realtime, $signed(out_ch.value));
        end else begin
          exp_r = trig_expected.pop_front();
          if (out_ch.value !== exp_r.value) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("[%0t] mismatch: mode %s angle %0d expected %0d got %0d",
                       $realtime, exp_r.mode.name(), exp_r.angle, exp_r.value,
                       $signed(out_ch.value));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        m_in = trig_mode_t'(in_ch.mode);
        trig_expected.push_back('{m_in, in_ch.angle, predict_trig(m_in, in_ch.angle)});
        items_sent++;
        if (m_in == MODE_SIN) sine_items++;
        if (in_ch.angle < 0) neg_items++;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    angle_item_t       it;
    int                a;
    int                idx;
    int                leftover;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_COS;
    in_ch.angle  = '0;
    out_ch.ready = 1'b0;

    // corner angles in both modes
    for (idx = 0; idx < N_CORNER; idx++) begin
      angle_queue.push_back('{MODE_COS, CORNER_ANGLES[idx], 1'b0});
      angle_queue.push_back('{MODE_SIN, CORNER_ANGLES[idx], 1'b0});
    end

    // random mix; a few items wait for the pipeline to empty first
    for (idx = 0; idx < N_RANDOM; idx++) begin
      case ($urandom_range(0, 9)) inside
        [0:4]:   a = $urandom_range(0, 65535);
        [5:6]:   a = $urandom_range(0, 1023) - 512;
        default: begin
          a = $urandom_range(0, 5) * QUARTER_TURN + $urandom_range(0, 16) - 8;
          if ($urandom_range(0, 1)) a = -a;
        end
      endcase
      it.mode       = trig_mode_t'($urandom_range(0, 1));
      it.angle      = a[ANGLE_W-1:0];
      it.wait_drain = (idx == 0) || (idx == 450) || (idx == 700);
      angle_queue.push_back(it);
    end

    burst_left = $urandom_range(1, 40);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (angle_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (trig_expected.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    leftover = trig_expected.size();
    $display("covered %0d items (%0d sine, %0d negative angles), %0d results checked",
             items_sent, sine_items, neg_items, results_seen);
    $display("output hold-off of %0d cycles, %0d drain pauses, %0d failures, %0d left over",
             LONG_HOLD, drain_pauses, fail_count, leftover);
    if (fail_count == 0 && leftover == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/scu_pkg.sv
design/scu_if.sv
design/scu_front.sv
design/scu_cell.sv
design/scu_back.sv
design/sine_cosine_unit.sv
tb/tb_top.sv
